/* hdl/sfe_pkg.sv */
// ----------------------------------------------------------------------------
// sfe_pkg
// Types, constants and the control store for the serial-bus frame encoder.
// ----------------------------------------------------------------------------
package sfe_pkg;

   localparam int NUM_CH      = 18;
   localparam int PACK_CH     = 16;
   localparam int CH_W        = 5;
   localparam int VAL_W       = 12;
   localparam int PACK_W      = 11;
   localparam int ACC_W       = 18;   // up to 7 leftover bits plus one 11-bit value
   localparam int NBITS_W     = 5;
   localparam int STEP_W      = 3;

   localparam logic [7:0]       START_BYTE   = 8'h0F;
   localparam logic [7:0]       END_BYTE     = 8'h00;
   localparam logic [VAL_W-1:0] THRESH_RESET = 12'd1500;
   localparam logic [VAL_W-1:0] CH0_RESET    = 12'd1023;

   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_SEND  = 1'b1;

   typedef struct packed {
      logic             kind;
      logic [CH_W-1:0]  channel;
      logic [VAL_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       last_byte;
   } rsp_type;

   typedef enum logic [2:0] {
      OP_NOP,
      OP_START,
      OP_LOAD,
      OP_EMIT,
      OP_FLAGS,
      OP_END
   } op_type;

   typedef enum logic [1:0] {
      COND_NEVER,
      COND_MORE,     // another full byte remains in the accumulator
      COND_CH_LEFT   // channels still to be packed
   } cond_type;

   typedef logic [STEP_W-1:0] step_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type target;
   } ctrl_type;

   typedef struct packed {
      logic more;
      logic ch_left;
   } stat_type;

   localparam step_type STEP_START = 3'd0;
   localparam step_type STEP_LOAD  = 3'd1;
   localparam step_type STEP_EMIT  = 3'd2;
   localparam step_type STEP_NEXT  = 3'd3;
   localparam step_type STEP_FLAGS = 3'd4;
   localparam step_type STEP_END   = 3'd5;

   // microprogram
   function automatic ctrl_type ucode(input step_type step);
      ctrl_type cw;
      cw = '{op: OP_NOP, cond: COND_NEVER, target: STEP_START};
      unique case (step)
         STEP_START: cw = '{op: OP_START, cond: COND_NEVER,   target: STEP_START};
         STEP_LOAD:  cw = '{op: OP_LOAD,  cond: COND_NEVER,   target: STEP_START};
         STEP_EMIT:  cw = '{op: OP_EMIT,  cond: COND_MORE,    target: STEP_EMIT};
         STEP_NEXT:  cw = '{op: OP_NOP,   cond: COND_CH_LEFT, target: STEP_LOAD};
         STEP_FLAGS: cw = '{op: OP_FLAGS, cond: COND_NEVER,   target: STEP_START};
         STEP_END:   cw = '{op: OP_END,   cond: COND_NEVER,   target: STEP_START};
         default:    cw = '{op: OP_NOP,   cond: COND_NEVER,   target: STEP_START};
      endcase
      return cw;
   endfunction

endpackage

/* hdl/sfe_seq.sv */
// ----------------------------------------------------------------------------
// sfe_seq
// Step counter and control store; issues one control word per cycle.
// ----------------------------------------------------------------------------
module sfe_seq (
   input  logic              clock,
   input  logic              reset,
   input  logic              go,
   input  sfe_pkg::stat_type stat,
   output sfe_pkg::ctrl_type ctrl,
   output logic              busy
);
   import sfe_pkg::*;

   logic     run_ff, run_in;
   step_type step_ff, step_in;
   ctrl_type cw;
   logic     take;

   always_comb begin
      cw     = ucode(step_ff);
      take   = 1'b0;
      run_in = run_ff;
      step_in = step_ff;
      unique case (cw.cond)
         COND_MORE:    take = stat.more;
         COND_CH_LEFT: take = stat.ch_left;
         default:      take = 1'b0;
      endcase
      if (run_ff) begin
         step_in = take ? cw.target : step_ff + STEP_W'(1);
         if (cw.op == OP_END) begin
            run_in = 1'b0;
         end
      end else if (go) begin
         run_in  = 1'b1;
         step_in = STEP_START;
      end
      ctrl = cw;
      if (!run_ff) begin
         ctrl.op = OP_NOP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         step_ff <= STEP_START;
      end else begin
         run_ff  <= run_in;
         step_ff <= step_in;
      end
   end

   assign busy = run_ff;

endmodule

/* hdl/sfe_datapath.sv */
// ----------------------------------------------------------------------------
// sfe_datapath
// Channel store, threshold register, bit accumulator and output register.
// ----------------------------------------------------------------------------
module sfe_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          wr_en,
   input  sfe_pkg::req_type              req,
   input  logic                          csr_wr_en,
   input  logic [sfe_pkg::VAL_W-1:0]     csr_wr_data,
   input  sfe_pkg::ctrl_type             ctrl,
   output sfe_pkg::stat_type             stat,
   output logic                          rsp_valid,
   output sfe_pkg::rsp_type              rsp_data
);
   import sfe_pkg::*;

   logic [VAL_W-1:0]   store_ff [NUM_CH];
   logic [VAL_W-1:0]   thr_ff;
   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic [NBITS_W-1:0] nbits_ff, nbits_in;
   logic [CH_W-1:0]    ch_ff, ch_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;
   logic [VAL_W-1:0]   cur_val;

   assign cur_val = store_ff[ch_ff];

   always_comb begin
      acc_in       = acc_ff;
      nbits_in     = nbits_ff;
      ch_in        = ch_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      unique case (ctrl.op)
         OP_START: begin
            acc_in       = '0;
            nbits_in     = '0;
            ch_in        = '0;
            rsp_valid_in = 1'b1;
            rsp_in       = '{frame_byte: START_BYTE, last_byte: 1'b0};
         end
         OP_LOAD: begin
            acc_in   = acc_ff | (ACC_W'(cur_val[PACK_W-1:0]) << nbits_ff);
            nbits_in = nbits_ff + NBITS_W'(PACK_W);
            ch_in    = ch_ff + CH_W'(1);
         end
         OP_EMIT: begin
            acc_in       = acc_ff >> 8;
            nbits_in     = nbits_ff - NBITS_W'(8);
            rsp_valid_in = 1'b1;
            rsp_in       = '{frame_byte: acc_ff[7:0], last_byte: 1'b0};
         end
         OP_FLAGS: begin
            rsp_valid_in = 1'b1;
            rsp_in       = '{frame_byte: {6'b0, store_ff[17] > thr_ff, store_ff[16] > thr_ff},
                             last_byte: 1'b0};
         end
         OP_END: begin
            rsp_valid_in = 1'b1;
            rsp_in       = '{frame_byte: END_BYTE, last_byte: 1'b1};
         end
         default: begin
         end
      endcase
   end

   // more: at least 8 bits stay after the byte going out now
   assign stat.more    = nbits_ff >= NBITS_W'(16);
   assign stat.ch_left = ch_ff != CH_W'(PACK_CH);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CH; i++) begin
            store_ff[i] <= '0;
         end
         store_ff[0]  <= CH0_RESET;
         thr_ff       <= THRESH_RESET;
         rsp_valid_ff <= 1'b0;
         ch_ff        <= '0;
         nbits_ff     <= '0;
      end else begin
         if (wr_en && req.channel < CH_W'(NUM_CH)) begin
            store_ff[req.channel] <= req.value;
         end
         if (csr_wr_en) begin
            thr_ff <= csr_wr_data;
         end
         rsp_valid_ff <= rsp_valid_in;
         ch_ff        <= ch_in;
         nbits_ff     <= nbits_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* hdl/sbus_frame_encoder.sv */
// Channel write: busy stays low, no beat out.
// Send: busy while the sequencer runs; beats leave in the cycle after their microcode step,
//   25 beats over the frame, paced by the sequencer (load, emit, channel check).
// Results are strobed for one cycle; the receiver cannot stall.
// Reset: sequencer idle, channel 0 = 1023, other channels 0, threshold 1500.
// ----------------------------------------------------------------------------
// sbus_frame_encoder
// Builds 25-byte, 16-channel 11-bit frames from a small channel store.
// ----------------------------------------------------------------------------
module sbus_frame_encoder (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  sfe_pkg::req_type          req_data,
   output logic                      rsp_valid,
   output sfe_pkg::rsp_type          rsp_data,
   input  logic                      csr_wr_en,
   input  logic [sfe_pkg::VAL_W-1:0] csr_wr_data
);
   import sfe_pkg::*;

   logic     accept;
   logic     go;
   logic     wr_en;
   ctrl_type ctrl;
   stat_type stat;

   assign accept = start && !busy;
   assign go     = accept && (req_data.kind == KIND_SEND);
   assign wr_en  = accept && (req_data.kind == KIND_WRITE);

   sfe_seq u_seq (
      .clock (clock),
      .reset (reset),
      .go    (go),
      .stat  (stat),
      .ctrl  (ctrl),
      .busy  (busy)
   );

   sfe_datapath u_dp (
      .clock       (clock),
      .reset       (reset),
      .wr_en       (wr_en),
      .req         (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .ctrl        (ctrl),
      .stat        (stat),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data)
   );

endmodule

/* tb/sbus_frame_encoder_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sbus_frame_encoder_test
// Self-checking bench for the frame encoder. Channel writes and send
// requests are driven through the start/busy handshake. A scoreboard keeps
// its own copy of the channel store and the threshold, builds each 25-byte
// frame as it is requested, and checks every strobed beat in order. The
// threshold is changed between traffic phases, only while the block is idle.
// ----------------------------------------------------------------------------
module sbus_frame_encoder_test;
   import sfe_pkg::*;

   localparam int               FRAME_BYTES   = 25;
   localparam logic [7:0]       SOF_BYTE      = 8'h0F;
   localparam logic [7:0]       EOF_BYTE      = 8'h00;
   localparam logic [VAL_W-1:0] CH0_AT_RESET  = 12'd1023;
   localparam logic [VAL_W-1:0] THR_AT_RESET  = 12'd1500;
   localparam int               SETTLE_CYCLES = 64;     // send keeps the block busy while its sequencer runs
   localparam int               DRAIN_GUARD   = 4000;
   localparam int               CYCLE_LIMIT   = 200000;
   localparam int               PHASE_ITEMS   = 50;

   class frame_checker;
      logic [VAL_W-1:0] chan_vals [NUM_CH];
      logic [VAL_W-1:0] threshold;
      rsp_type          pending_bytes [$];
      int               errors;
      int               beats_seen;
      int               writes_seen;
      int               sends_seen;

      function new();
         int i;
         for (i = 0; i < NUM_CH; i++) chan_vals[i] = '0;
         chan_vals[0] = CH0_AT_RESET;
         threshold    = THR_AT_RESET;
         errors       = 0;
         beats_seen   = 0;
         writes_seen  = 0;
         sends_seen   = 0;
      endfunction

      function void set_threshold(logic [VAL_W-1:0] v);
         threshold = v;
      endfunction

      function int pending();
         return pending_bytes.size();
      endfunction

      task report(string msg);
         errors++;
         $display("[%0t] mismatch: %s", $time, msg);
      endtask

      function void queue_byte(logic [7:0] v, logic last);
         rsp_type b;
         b.frame_byte = v;
         b.last_byte  = last;
         pending_bytes.push_back(b);
      endfunction

      // one accepted beat on the request side
      function void take_request(req_type r);
         logic [PACK_CH*PACK_W-1:0] packed_bits;
         int i;
         if (r.kind == KIND_WRITE) begin
            writes_seen++;
            if (r.channel < NUM_CH) chan_vals[r.channel] = r.value;
            return;
         end
         sends_seen++;
         // channels laid end to end, LSB first; bit 11 dropped
         for (i = 0; i < PACK_CH; i++) packed_bits[i*PACK_W +: PACK_W] = chan_vals[i][PACK_W-1:0];
         queue_byte(SOF_BYTE, 1'b0);
         for (i = 0; i < PACK_CH*PACK_W/8; i++) queue_byte(packed_bits[i*8 +: 8], 1'b0);
         queue_byte({6'b0, chan_vals[17] > threshold, chan_vals[16] > threshold}, 1'b0);
         queue_byte(EOF_BYTE, 1'b1);
      endfunction

      task check_beat(rsp_type got);
         rsp_type want;
         int      pos;
         pos = beats_seen % FRAME_BYTES;
         beats_seen++;
         if (pending_bytes.size() == 0) begin
            report($sformatf("unexpected beat byte=%02h last=%0b", got.frame_byte, got.last_byte));
            return;
         end
         want = pending_bytes.pop_front();
         if (got.frame_byte !== want.frame_byte)
            report($sformatf("frame byte %0d: got %02h want %02h",
                             pos, got.frame_byte, want.frame_byte));
         if (got.last_byte !== want.last_byte)
            report($sformatf("frame byte %0d: last got %0b want %0b",
                             pos, got.last_byte, want.last_byte));
      endtask
   endclass

   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             start       = 1'b0;
   req_type          req_data    = '0;
   logic             csr_wr_en   = 1'b0;
   logic [VAL_W-1:0] csr_wr_data = '0;
   logic             busy;
   logic             rsp_valid;
   rsp_type          rsp_data;

   frame_checker sb;
   int           thresholds_used = 0;

   sbus_frame_encoder i_dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // sample both channels at the edge; results are checked before new requests
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) sb.check_beat(rsp_data);
         if (start && !busy) sb.take_request(req_data);
      end
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("timeout after %0d cycles", CYCLE_LIMIT);
      $display("[sbus_frame_encoder] ERROR");
      $finish;
   end

   function automatic req_type mk_req(logic k, int ch, int v);
      req_type r;
      r.kind    = k;
      r.channel = ch[CH_W-1:0];
      r.value   = v[VAL_W-1:0];
      return r;
   endfunction

   function automatic req_type rand_req();
      int      pick;
      int      ch;
      int      v;
      pick = $urandom_range(99);
      v    = $urandom;
      if (pick < 15) return mk_req(KIND_SEND, $urandom_range(31), v);
      if (pick < 20) return mk_req(KIND_WRITE, $urandom_range(31, NUM_CH), v);
      ch = $urandom_range(NUM_CH - 1);
      // flag channels often land right at the threshold
      if (ch >= PACK_CH && $urandom_range(1))
         v = int'(sb.threshold) + $urandom_range(2) - 1;
      return mk_req(KIND_WRITE, ch, v);
   endfunction

   function automatic int idle_gap(int pct);
      int n;
      n = 0;
      while (n < 30 && $urandom_range(99) < pct) n++;
      return n;
   endfunction

   // called just after a rising edge; gap 0 keeps start high for the next beat
   task automatic issue(input req_type r, input int gap);
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      int guard;
      guard = 0;
      while (sb.pending() > 0 && guard < DRAIN_GUARD) begin
         @(posedge clock);
         guard++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [VAL_W-1:0] v);
      drain_results();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.set_threshold(v);
      thresholds_used++;
   endtask

   task automatic run_phase(input int n, input int pct, input bit hold_off);
      int      i;
      int      gap;
      bit      stop_here;
      req_type r;
      for (i = 0; i < n; i++) begin
         r         = rand_req();
         stop_here = (i == n - 1) || (hold_off && i == n / 2);
         gap       = idle_gap(pct);
         if (stop_here && gap == 0) gap = 1;
         issue(r, gap);
         if (hold_off && i == n / 2) drain_results();
      end
   endtask

   initial begin
      req_type dq [$];
      int      i;

      sb = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      dq.push_back(mk_req(KIND_SEND,  0, 0));        // frame straight out of reset
      dq.push_back(mk_req(KIND_WRITE, 0, 4095));     // bit 11 must be dropped
      dq.push_back(mk_req(KIND_WRITE, 15, 2048));
      dq.push_back(mk_req(KIND_WRITE, 7, 2047));
      dq.push_back(mk_req(KIND_WRITE, 16, 1501));
      dq.push_back(mk_req(KIND_WRITE, 17, 1500));
      dq.push_back(mk_req(KIND_WRITE, 18, 'hABC));   // out of range, ignored
      dq.push_back(mk_req(KIND_WRITE, 31, 'hFFF));
      dq.push_back(mk_req(KIND_SEND,  31, 'hFFF));   // fields of a send are don't-care
      dq.push_back(mk_req(KIND_WRITE, 16, 1500));
      dq.push_back(mk_req(KIND_WRITE, 17, 4095));
      dq.push_back(mk_req(KIND_SEND,  0, 0));
      dq.push_back(mk_req(KIND_WRITE, 16, 4095));
      dq.push_back(mk_req(KIND_WRITE, 1, 'h555));
      dq.push_back(mk_req(KIND_WRITE, 2, 'h2AA));
      dq.push_back(mk_req(KIND_WRITE, 14, 0));
      dq.push_back(mk_req(KIND_SEND,  17, 'h800));
      dq.push_back(mk_req(KIND_WRITE, 16, 0));
      dq.push_back(mk_req(KIND_WRITE, 17, 0));
      dq.push_back(mk_req(KIND_SEND,  0, 0));
      for (i = 0; i < dq.size(); i++) issue(dq[i], (i == dq.size() - 1) ? 1 : 0);

      write_threshold(12'd0);
      run_phase(PHASE_ITEMS, 0, 1'b1);
      write_threshold(12'd4095);
      run_phase(PHASE_ITEMS, 47, 1'b0);
      write_threshold(12'($urandom));
      run_phase(PHASE_ITEMS, 10, 1'b0);
      write_threshold(THR_AT_RESET);
      run_phase(PHASE_ITEMS, 47, 1'b1);

      drain_results();
      if (sb.pending() > 0)
         sb.report($sformatf("%0d frame beats never arrived", sb.pending()));

      $display("covered %0d channel writes and %0d frame requests, %0d beats checked",
               sb.writes_seen, sb.sends_seen, sb.beats_seen);
      $display("threshold changed %0d times, sender idle at 0/47/10 percent, %0d mismatches",
               thresholds_used, sb.errors);
      if (sb.errors == 0) begin
         $display("[sbus_frame_encoder] OK");
      end else begin
         $display("[sbus_frame_encoder] ERROR");
      end
      $finish;
   end

endmodule

/* sbus_frame_encoder.f */
hdl/sfe_pkg.sv
hdl/sfe_seq.sv
hdl/sfe_datapath.sv
hdl/sbus_frame_encoder.sv
tb/sbus_frame_encoder_test.sv
